// ===== hw/rtl/e2u_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2u_pkg
// Shared types, constants and lookup functions for the epoch-to-UTC converter.
// ----------------------------------------------------------------------------
package e2u_pkg;

   // Reciprocal scale: quotient estimate is (a * recip) >> RECIP_SHIFT.
   localparam int unsigned RECIP_SHIFT = 29;
   localparam int unsigned DIVIDEND_W  = 29;
   localparam int unsigned RECIP_W     = 24;
   localparam int unsigned DIVISOR_W   = 12;
   localparam int unsigned QUOT_W      = 24;
   localparam int unsigned PROD_W      = DIVIDEND_W + RECIP_W;

   localparam logic [6:0] CENT_LAST  = 7'd99;   // (y-1) % 100 when y % 100 == 0
   localparam logic [8:0] QUAD_LAST  = 9'd399;  // (y-1) % 400 when y % 400 == 0
   localparam logic [3:0] MONTH_FEB  = 4'd1;
   localparam logic [3:0] MONTH_LAST = 4'd11;

   typedef enum logic [2:0] {
      DIV_DAY  = 3'd0,
      DIV_HOUR = 3'd1,
      DIV_MIN  = 3'd2,
      DIV_Y366 = 3'd3,
      DIV_C100 = 3'd4,
      DIV_C400 = 3'd5
   } e2u_div_sel_type;

   typedef struct packed {
      logic                    start;
      e2u_div_sel_type         sel;
      logic [DIVIDEND_W-1:0]   dividend;
   } e2u_div_req_type;

   typedef struct packed {
      logic                    done;
      logic [QUOT_W-1:0]       quot;
      logic [DIVISOR_W-1:0]    rem;
   } e2u_div_rsp_type;

   // floor(2^29 / divisor)
   function automatic logic [RECIP_W-1:0] div_recip(input e2u_div_sel_type sel);
      logic [RECIP_W-1:0] m;
      unique case (sel)
         DIV_DAY:  m = 24'd795364;    // 675 (86400 with the low 7 bits split off)
         DIV_HOUR: m = 24'd149130;    // 3600
         DIV_MIN:  m = 24'd8947848;   // 60
         DIV_Y366: m = 24'd1466860;   // 366
         DIV_C100: m = 24'd5368709;   // 100
         DIV_C400: m = 24'd1342177;   // 400
         default:  m = '0;
      endcase
      return m;
   endfunction

   function automatic logic [DIVISOR_W-1:0] div_const(input e2u_div_sel_type sel);
      logic [DIVISOR_W-1:0] d;
      unique case (sel)
         DIV_DAY:  d = 12'd675;
         DIV_HOUR: d = 12'd3600;
         DIV_MIN:  d = 12'd60;
         DIV_Y366: d = 12'd366;
         DIV_C100: d = 12'd100;
         DIV_C400: d = 12'd400;
         default:  d = 12'd1;
      endcase
      return d;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      unique case (m)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
         MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/epoch_seconds_to_utc_date.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_date
// Converts seconds since 1970-01-01 00:00:00 UTC to Gregorian date and time.
//
// One beat in, one beat out. The block is busy for the whole conversion and
// takes a new request only once the previous response has been taken. All
// divisions go through one shared divide-by-constant unit (reciprocal
// multiply plus one correction): three divisions for the time of day and
// whole-day count, then three per year-search pass (days/366, (y-1)/100,
// (y-1)/400) followed by an update and a check state. The year search needs
// no pass within 1970 and at most three passes otherwise. The month walk
// steps one month per cycle.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_date (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [35:0] req_epoch_seconds,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [12:0]      rsp_year,
   output logic [3:0]       rsp_month,
   output logic [4:0]       rsp_day_of_month,
   output logic [4:0]       rsp_hour,
   output logic [5:0]       rsp_minute,
   output logic [5:0]       rsp_second
);
   import e2u_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIV  = 7'b0000010,
      ST_CHK  = 7'b0000100,
      ST_UPD  = 7'b0001000,
      ST_ADJ  = 7'b0010000,
      ST_MON  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   e2u_div_req_type  div_req_ff, div_req_in;
   e2u_div_rsp_type  div_rsp;

   logic [6:0]  secs_lo_ff, secs_lo_in;
   logic [19:0] days_ff, days_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic [12:0] y_ff, y_in;
   logic [12:0] ym1_ff, ym1_in;
   logic [11:0] q366_ff, q366_in;
   logic [8:0]  r366_ff, r366_in;
   logic [5:0]  q100_ff, q100_in;
   logic [6:0]  r100_ff, r100_in;
   logic [3:0]  q400_ff, q400_in;
   logic [8:0]  r400_ff, r400_in;
   logic [10:0] lold_ff, lold_in;
   logic [3:0]  mon_ff, mon_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [12:0] o_year_ff, o_year_in;
   logic [3:0]  o_month_ff, o_month_in;
   logic [4:0]  o_day_ff, o_day_in;

   logic        leap;
   logic [10:0] lnew;
   logic [20:0] days_sum;
   logic [4:0]  mlen;

   e2u_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   // Leap test for y from the remainders of y-1: y % 100 == 0 exactly when
   // (y-1) % 100 is 99, and likewise for 400.
   assign leap = (ym1_ff[1:0] == 2'd3) && ((r100_ff != CENT_LAST) || (r400_ff == QUAD_LAST));

   // Leap years in 1..(ny-1), and the days left after skipping to ny:
   // days - q*366 - (leaps) + q  ==  r366 + q + lold - lnew.
   assign lnew     = 11'(ym1_ff[12:2]) - 11'(q100_ff) + 11'(q400_ff);
   assign days_sum = 21'(r366_ff) + 21'(q366_ff) + 21'(lold_ff) - 21'(lnew);

   assign mlen = month_len(mon_ff, leap);

   always_comb begin
      state_in     = state_ff;
      div_req_in   = div_req_ff;
      div_req_in.start = 1'b0;
      secs_lo_in   = secs_lo_ff;
      days_in      = days_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      y_in         = y_ff;
      ym1_in       = ym1_ff;
      q366_in      = q366_ff;
      r366_in      = r366_ff;
      q100_in      = q100_ff;
      r100_in      = r100_ff;
      q400_in      = q400_ff;
      r400_in      = r400_ff;
      lold_in      = lold_ff;
      mon_in       = mon_ff;
      rsp_valid_in = rsp_valid_ff;
      o_year_in    = o_year_ff;
      o_month_in   = o_month_ff;
      o_day_in     = o_day_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // Split off the factor 128 of 86400; divide the rest by 675.
               secs_lo_in          = req_epoch_seconds[6:0];
               div_req_in.start    = 1'b1;
               div_req_in.sel      = DIV_DAY;
               div_req_in.dividend = req_epoch_seconds[35:7];
               // Year search starts at 1970, so seed the state for 1969.
               y_in    = 13'd1970;
               ym1_in  = 13'd1969;
               r100_in = 7'd69;
               r400_in = 9'd369;
               lold_in = 11'd477;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            if (div_rsp.done) begin
               unique case (div_req_ff.sel)
                  DIV_DAY: begin
                     days_in             = div_rsp.quot[19:0];
                     div_req_in.start    = 1'b1;
                     div_req_in.sel      = DIV_HOUR;
                     div_req_in.dividend = 29'({div_rsp.rem[9:0], secs_lo_ff});
                  end
                  DIV_HOUR: begin
                     hour_in             = div_rsp.quot[4:0];
                     div_req_in.start    = 1'b1;
                     div_req_in.sel      = DIV_MIN;
                     div_req_in.dividend = 29'(div_rsp.rem);
                  end
                  DIV_MIN: begin
                     minute_in = div_rsp.quot[5:0];
                     second_in = div_rsp.rem[5:0];
                     state_in  = ST_CHK;
                  end
                  DIV_Y366: begin
                     q366_in             = div_rsp.quot[11:0];
                     r366_in             = div_rsp.rem[8:0];
                     ym1_in              = y_ff + div_rsp.quot[12:0] - 13'd1;
                     div_req_in.start    = 1'b1;
                     div_req_in.sel      = DIV_C100;
                     div_req_in.dividend = 29'(ym1_in);
                  end
                  DIV_C100: begin
                     q100_in             = div_rsp.quot[5:0];
                     r100_in             = div_rsp.rem[6:0];
                     div_req_in.start    = 1'b1;
                     div_req_in.sel      = DIV_C400;
                     div_req_in.dividend = 29'(ym1_ff);
                  end
                  DIV_C400: begin
                     q400_in  = div_rsp.quot[3:0];
                     r400_in  = div_rsp.rem[8:0];
                     state_in = ST_UPD;
                  end
                  default: state_in = ST_CHK;
               endcase
            end
         end

         ST_UPD: begin
            // Advance to the guessed year and drop the days skipped.
            days_in  = days_sum[19:0];
            lold_in  = lnew;
            y_in     = ym1_ff + 13'd1;
            state_in = ST_CHK;
         end

         ST_CHK: begin
            if (days_ff > 20'd365) begin
               div_req_in.start    = 1'b1;
               div_req_in.sel      = DIV_Y366;
               div_req_in.dividend = 29'(days_ff);
               state_in            = ST_DIV;
            end else begin
               state_in = ST_ADJ;
            end
         end

         ST_ADJ: begin
            // Day 365 of a common year rolls over to January 1 of the next.
            if ((days_ff == 20'd365) && !leap) begin
               days_in = '0;
               y_in    = y_ff + 13'd1;
            end
            mon_in   = '0;
            state_in = ST_MON;
         end

         ST_MON: begin
            if ((mon_ff < MONTH_LAST) && (days_ff >= 20'(mlen))) begin
               days_in = days_ff - 20'(mlen);
               mon_in  = mon_ff + 4'd1;
            end else begin
               o_year_in    = y_ff;
               o_month_in   = mon_ff + 4'd1;
               o_day_in     = days_ff[4:0] + 5'd1;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end

         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_req_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_req_ff   <= div_req_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      secs_lo_ff <= secs_lo_in;
      days_ff    <= days_in;
      hour_ff    <= hour_in;
      minute_ff  <= minute_in;
      second_ff  <= second_in;
      y_ff       <= y_in;
      ym1_ff     <= ym1_in;
      q366_ff    <= q366_in;
      r366_ff    <= r366_in;
      q100_ff    <= q100_in;
      r100_ff    <= r100_in;
      q400_ff    <= q400_in;
      r400_ff    <= r400_in;
      lold_ff    <= lold_in;
      mon_ff     <= mon_in;
      o_year_ff  <= o_year_in;
      o_month_ff <= o_month_in;
      o_day_ff   <= o_day_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = o_year_ff;
   assign rsp_month        = o_month_ff;
   assign rsp_day_of_month = o_day_ff;
   assign rsp_hour         = hour_ff;
   assign rsp_minute       = minute_ff;
   assign rsp_second       = second_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/e2u_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2u_div
// Shared divide-by-constant unit: reciprocal multiply, back-multiply, one
// correction step, each registered in turn.
// ----------------------------------------------------------------------------
module e2u_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire e2u_pkg::e2u_div_req_type req,
   output e2u_pkg::e2u_div_rsp_type   rsp
);
   import e2u_pkg::*;

   logic                   v1_ff, v2_ff, done_ff;
   logic [DIVIDEND_W-1:0]  a_ff, a_in;
   logic [DIVISOR_W-1:0]   d_ff, d_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [QUOT_W-1:0]      qe_ff, qe_in;
   logic [DIVIDEND_W-1:0]  qd_ff, qd_in;
   logic [QUOT_W-1:0]      q_ff, q_in;
   logic [DIVISOR_W-1:0]   r_ff, r_in;
   logic [DIVIDEND_W-1:0]  r_raw;
   logic [DIVIDEND_W+DIVISOR_W-1:0] qd_full;

   always_comb begin
      a_in    = a_ff;
      d_in    = d_ff;
      prod_in = prod_ff;
      if (req.start) begin
         a_in    = req.dividend;
         d_in    = div_const(req.sel);
         prod_in = PROD_W'(req.dividend) * PROD_W'(div_recip(req.sel));
      end
   end

   // Estimate is exact or one short.
   always_comb begin
      qe_in   = prod_ff[RECIP_SHIFT +: QUOT_W];
      qd_full = (DIVIDEND_W+DIVISOR_W)'(qe_in) * (DIVIDEND_W+DIVISOR_W)'(d_ff);
      qd_in   = qd_full[DIVIDEND_W-1:0];
   end

   always_comb begin
      r_raw = a_ff - qd_ff;
      if (r_raw[DIVISOR_W:0] >= {1'b0, d_ff}) begin
         q_in = qe_ff + QUOT_W'(1);
         r_in = r_raw[DIVISOR_W-1:0] - d_ff;
      end else begin
         q_in = qe_ff;
         r_in = r_raw[DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= req.start;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      d_ff    <= d_in;
      prod_ff <= prod_in;
      if (v1_ff) begin
         qe_ff <= qe_in;
         qd_ff <= qd_in;
      end
      if (v2_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign rsp = {done_ff, q_ff, r_ff};

endmodule
`default_nettype wire
